[design/sqrp_pkg.sv]
// ----------------------------------------------------------------------------
// sqrp_pkg: shared types and constants of the sensor query retry parser
// Holds the sequencer state type, result codes and the fixed command text.
// ----------------------------------------------------------------------------
package sqrp_pkg;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_TX     = 1'b1;

  // Status codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  // Protocol bytes
  localparam logic [7:0] CR_BYTE    = 8'h0d;
  localparam logic [7:0] QUERY_MARK = 8'h3f;  // '?'
  localparam logic [7:0] NUL_BYTE   = 8'h00;

  // Command lengths
  localparam int PREFIX_LEN    = 3;   // "ID="
  localparam int ID_CMD_LEN    = 5;   // "ID=?" and its NUL
  localparam int TAIL_LEN      = 5;   // " BT=?"
  localparam int VALUE_CMD_LEN = 32;
  localparam int VALUE_SKIP    = 6;   // first byte that may follow "BT="

  // Configuration
  localparam logic [3:0] RETRY_LIMIT_RESET = 4'd3;
  localparam logic [3:0] RETRY_MAX         = 4'd15;

  // Sequencer states
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_HEAD   = 8'b0000_1000,
    S_IDQ    = 8'b0001_0000,
    S_IDENT  = 8'b0010_0000,
    S_TAIL   = 8'b0100_0000,
    S_STAT   = 8'b1000_0000
  } state_t;

  // Byte of the "ID=" prefix
  function automatic logic [7:0] head_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h49;  // 'I'
      2'd1:    c = 8'h44;  // 'D'
      2'd2:    c = 8'h3d;  // '='
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Byte of the " BT=?" tail, zero past its end
  function automatic logic [7:0] tail_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h20;  // ' '
      3'd1:    c = 8'h42;  // 'B'
      3'd2:    c = 8'h54;  // 'T'
      3'd3:    c = 8'h3d;  // '='
      3'd4:    c = 8'h3f;  // '?'
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[design/sensor_query_retry_parser_top.sv]
// ----------------------------------------------------------------------------
// sensor_query_retry_parser_top: two-phase presence sensor poller
// Buffers received bytes, parses identity and value replies on a poll, and
// emits query bytes and a status beat.
// ----------------------------------------------------------------------------
// A byte item (mode 0) appends rx_byte to the packet buffer, dropping it
// once PACKET_MAX bytes are held. A poll (mode 1) streams the buffer
// through one compare unit, one byte per cycle from the buffer memory,
// skipping the scan when 3 or fewer bytes are buffered. A decision state
// follows, then one output beat per cycle while out_stall is low: 1 status
// beat, plus 5 query bytes in the identity phase or 32 in the value phase
// on a retry. in_stall stays high until the poll's status beat has been
// loaded into the output register.
// ----------------------------------------------------------------------------
module sensor_query_retry_parser_top
  import sqrp_pkg::*;
#(
  parameter int PACKET_MAX = 64,
  parameter int ID_MAX     = 23
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [1:0]  status,
  output logic [7:0]  tx_byte,
  output logic [3:0]  sensor_value,
  output logic        last
);

  localparam int AW = $clog2(PACKET_MAX);
  localparam int CW = $clog2(PACKET_MAX + 1);
  localparam int IW = (ID_MAX > 1) ? $clog2(ID_MAX) : 1;
  localparam int LW = $clog2(ID_MAX + 1);

  // Memories and stores
  logic [7:0] mem [PACKET_MAX];
  logic [7:0] tmp_id [ID_MAX];
  logic [7:0] id_store [ID_MAX];

  // Control registers
  state_t     state;
  logic [CW-1:0] count;
  logic       phase;
  logic [LW-1:0] id_length;
  logic [3:0] retry_count;
  logic [3:0] retry_limit;

  // Scan pipeline
  logic [CW-1:0] ridx;
  logic [CW-1:0] pidx;
  logic       pvld;
  logic [7:0] rd_data;
  logic [7:0] w1, w2, w3;
  logic [LW-1:0] n;
  logic       scan_ok;
  logic [3:0] scan_val;

  // Emit counters and status
  logic [4:0] tk;
  logic [LW-1:0] j;
  logic [2:0] t;
  logic [1:0] stat_code;
  logic [3:0] stat_val;

  // Beat to load
  logic       adv;
  logic       beat_vld;
  logic       beat_kind;
  logic [1:0] beat_status;
  logic [7:0] beat_byte;
  logic [3:0] beat_val;
  logic       beat_last;
  logic       id_ok;

  // Scan compare unit
  logic prefix_bad, hit, last_byte, miss, byte_take, id_take;

  // Configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {28'd0, retry_limit} : 32'd0;

  assign in_stall = (state != S_IDLE);
  assign byte_take = (state == S_IDLE) && in_valid && !mode &&
                     (count < CW'(PACKET_MAX));

  // Compare the current buffer byte against the prefix and the terminators
  always_comb begin
    prefix_bad = pvld && (pidx < CW'(PREFIX_LEN)) && (rd_data != head_char(pidx[1:0]));
    if (phase == 1'b0) begin
      hit = pvld && (pidx >= CW'(PREFIX_LEN)) && (rd_data == CR_BYTE);
    end else begin
      hit = pvld && (pidx >= CW'(VALUE_SKIP)) && (w3 == 8'h42) &&
            (w2 == 8'h54) && (w1 == 8'h3d);
    end
    hit       = hit && !prefix_bad;
    last_byte = pvld && (pidx == count - CW'(1));
    miss      = prefix_bad || (!hit && last_byte);
    id_take   = (state == S_SCAN) && pvld && (phase == 1'b0) &&
                (pidx >= CW'(PREFIX_LEN)) && !hit && !prefix_bad &&
                (n < LW'(ID_MAX));
  end

  // Select the next output beat
  assign adv   = !out_valid || !out_stall;
  assign id_ok = (j < id_length) && (id_store[j[IW-1:0]] != NUL_BYTE);

  always_comb begin
    beat_vld    = 1'b0;
    beat_kind   = KIND_TX;
    beat_status = ST_IDLE;
    beat_byte   = NUL_BYTE;
    beat_val    = 4'd0;
    beat_last   = 1'b0;
    case (state)
      S_HEAD: begin
        beat_vld  = 1'b1;
        beat_byte = head_char(tk[1:0]);
      end
      S_IDQ: begin
        beat_vld  = 1'b1;
        beat_byte = (tk == 5'(PREFIX_LEN)) ? QUERY_MARK : NUL_BYTE;
      end
      S_IDENT: begin
        beat_vld  = 1'b1;
        beat_byte = id_ok ? id_store[j[IW-1:0]] : tail_char(3'd0);
      end
      S_TAIL: begin
        beat_vld  = 1'b1;
        beat_byte = tail_char(t);
      end
      S_STAT: begin
        beat_vld    = 1'b1;
        beat_kind   = KIND_STATUS;
        beat_status = stat_code;
        beat_val    = stat_val;
        beat_last   = 1'b1;
      end
      default: beat_vld = 1'b0;
    endcase
  end

  // Buffer memory, scan read port and identity stores
  always_ff @(posedge clk) begin
    if (byte_take) begin
      mem[count[AW-1:0]] <= rx_byte;
    end
    rd_data <= mem[ridx[AW-1:0]];
    pidx    <= ridx;
    if (id_take) begin
      tmp_id[n[IW-1:0]] <= rd_data;
    end
    if (state == S_DECIDE && scan_ok && phase == 1'b0) begin
      id_store <= tmp_id;
    end
    if (state == S_SCAN && pvld) begin
      w1 <= rd_data;
      w2 <= w1;
      w3 <= w2;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= beat_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind         <= beat_kind;
      status       <= beat_status;
      tx_byte      <= beat_byte;
      sensor_value <= beat_val;
      last         <= beat_last;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      phase       <= 1'b0;
      id_length   <= '0;
      retry_count <= 4'd0;
      retry_limit <= RETRY_LIMIT_RESET;
      pvld        <= 1'b0;
      scan_ok     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        retry_limit <= pwdata[3:0];
      end
      case (state)
        S_IDLE: begin
          if (byte_take) begin
            count <= count + CW'(1);
          end
          if (in_valid && mode) begin
            ridx <= '0;
            pvld <= 1'b0;
            n    <= '0;
            if (count <= CW'(PREFIX_LEN)) begin
              scan_ok <= 1'b0;
              state   <= S_DECIDE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // issue the next read, then judge the byte returned
          pvld <= (ridx < count);
          if (ridx < count) begin
            ridx <= ridx + CW'(1);
          end
          if (id_take) begin
            n <= n + LW'(1);
          end
          if (hit) begin
            scan_ok  <= 1'b1;
            scan_val <= rd_data[3:0];
            state    <= S_DECIDE;
          end else if (miss) begin
            scan_ok <= 1'b0;
            state   <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          count <= '0;
          pvld  <= 1'b0;
          tk    <= 5'd0;
          j     <= '0;
          t     <= 3'd0;
          stat_code <= ST_IDLE;
          stat_val  <= 4'd0;
          if (scan_ok) begin
            if (phase == 1'b0) begin
              phase     <= 1'b1;
              id_length <= n;
            end else begin
              stat_code <= ST_OK;
              stat_val  <= scan_val;
            end
            state <= S_STAT;
          end else if (retry_count > retry_limit) begin
            retry_count <= 4'd0;
            phase       <= 1'b0;
            stat_code   <= ST_FAIL;
            state       <= S_STAT;
          end else begin
            if (retry_count < RETRY_MAX) begin
              retry_count <= retry_count + 4'd1;
            end
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (adv) begin
            tk <= tk + 5'd1;
            if (tk == 5'(PREFIX_LEN - 1)) begin
              state <= phase ? S_IDENT : S_IDQ;
            end
          end
        end
        S_IDQ: begin
          if (adv) begin
            tk <= tk + 5'd1;
            if (tk == 5'(ID_CMD_LEN - 1)) begin
              state <= S_STAT;
            end
          end
        end
        S_IDENT: begin
          if (adv) begin
            tk <= tk + 5'd1;
            if (id_ok) begin
              j <= j + LW'(1);
            end else begin
              t     <= 3'd1;
              state <= S_TAIL;
            end
          end
        end
        S_TAIL: begin
          // tail bytes, then zero padding to the full command length
          if (adv) begin
            tk <= tk + 5'd1;
            if (t < 3'(TAIL_LEN)) begin
              t <= t + 3'd1;
            end
            if (tk == 5'(VALUE_CMD_LEN - 1)) begin
              state <= S_STAT;
            end
          end
        end
        S_STAT: begin
          if (adv) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/sensor_query_retry_parser_checker.sv]
// ----------------------------------------------------------------------------
// sensor_query_retry_parser_checker: result predictor and scoreboard
// Watches the configuration port and both channels of the presence sensor
// poller, predicts every output beat from accepted input beats and compares
// them in order, field by field.
// ----------------------------------------------------------------------------
module sensor_query_retry_parser_checker
  import sqrp_pkg::*;
#(
  parameter int         PACKET_DEPTH = 64,
  parameter int         ID_DEPTH     = 23,
  parameter logic [2:0] LIMIT_ADDR   = 3'd0,
  parameter logic       POLL_MODE    = 1'b1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        kind,
  input  logic [1:0]  status,
  input  logic [7:0]  tx_byte,
  input  logic [3:0]  sensor_value,
  input  logic        last,
  output int          errors,
  output int          outstanding
);

  localparam logic PH_IDENT = 1'b0;
  localparam logic PH_VALUE = 1'b1;
  localparam int   MAX_PRINTED = 200;

  localparam logic [23:0] PREFIX_TXT   = "ID=";
  localparam logic [23:0] MARKER_TXT   = "BT=";
  localparam logic [39:0] TAIL_TXT     = " BT=?";
  localparam logic [39:0] ID_QUERY_TXT = {"ID=?", NUL_BYTE};

  typedef struct packed {
    logic       kind;
    logic [1:0] status;
    logic [7:0] tx_byte;
    logic [3:0] value;
    logic       last;
  } beat_t;

  beat_t      expected_beats[$];
  logic [7:0] pkt_mem [PACKET_DEPTH];
  int         pkt_count;
  logic [7:0] id_mem [ID_DEPTH];
  int         id_len;
  int         retries;
  logic       phase;
  logic [3:0] retry_lim;
  int         err_cnt = 0;
  int         beat_no = 0;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTED) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got_v,
                             input logic [7:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("beat %0d field %s: got %h, expected %h",
                                beat_no, name, got_v, want_v));
  endtask

  task automatic push_beat(input logic k, input logic [1:0] s, input logic [7:0] t,
                           input logic [3:0] v, input logic l);
    beat_t b;
    b = '{kind: k, status: s, tx_byte: t, value: v, last: l};
    expected_beats.push_back(b);
  endtask

  // Buffer starts with "ID=" and holds more than the prefix
  function automatic bit prefix_seen();
    bit hit;
    hit = pkt_count > PREFIX_LEN;
    for (int k = 0; k < PREFIX_LEN; k++)
      if (hit && pkt_mem[k] != PREFIX_TXT[8*(PREFIX_LEN-1-k) +: 8]) hit = 0;
    return hit;
  endfunction

  // Run one protocol step on the buffered bytes and queue its beats
  task automatic predict_poll();
    bit         ok;
    int         n;
    int         len;
    logic [3:0] val;
    logic [7:0] id_tmp [ID_DEPTH];
    logic [7:0] cmd [VALUE_CMD_LEN];
    ok  = 0;
    n   = 0;
    val = '0;
    if (prefix_seen()) begin
      if (phase == PH_IDENT) begin
        // capture identity up to the carriage return, keep first ID_DEPTH bytes
        for (int i = PREFIX_LEN; i < pkt_count; i++) begin
          if (!ok) begin
            if (pkt_mem[i] == CR_BYTE) begin
              for (int k = 0; k < n; k++) id_mem[k] = id_tmp[k];
              id_len = n;
              ok = 1;
            end else if (n < ID_DEPTH) begin
              id_tmp[n] = pkt_mem[i];
              n++;
            end
          end
        end
      end else begin
        // find "BT=" with a byte after it, inside the received bytes
        for (int j = PREFIX_LEN; j + 3 < pkt_count; j++) begin
          if (!ok && pkt_mem[j] == MARKER_TXT[23:16] && pkt_mem[j+1] == MARKER_TXT[15:8]
              && pkt_mem[j+2] == MARKER_TXT[7:0]) begin
            val = pkt_mem[j+3][3:0];
            ok  = 1;
          end
        end
      end
    end
    pkt_count = 0;

    if (ok) begin
      if (phase == PH_IDENT) begin
        phase = PH_VALUE;
        push_beat(KIND_STATUS, ST_IDLE, 8'h00, 4'h0, 1'b1);
      end else begin
        push_beat(KIND_STATUS, ST_OK, 8'h00, val, 1'b1);
      end
    end else if (retries > retry_lim) begin
      retries = 0;
      phase   = PH_IDENT;
      push_beat(KIND_STATUS, ST_FAIL, 8'h00, 4'h0, 1'b1);
    end else begin
      if (retries < RETRY_MAX) retries++;
      if (phase == PH_IDENT) begin
        for (int k = 0; k < ID_CMD_LEN; k++)
          push_beat(KIND_TX, ST_IDLE, ID_QUERY_TXT[8*(ID_CMD_LEN-1-k) +: 8], 4'h0, 1'b0);
      end else begin
        // "ID=" + identity up to its first zero byte + " BT=?", zero padded
        for (int k = 0; k < VALUE_CMD_LEN; k++) cmd[k] = NUL_BYTE;
        len = 0;
        for (int k = 0; k < PREFIX_LEN; k++) begin
          cmd[len] = PREFIX_TXT[8*(PREFIX_LEN-1-k) +: 8];
          len++;
        end
        for (int k = 0; k < id_len && id_mem[k] != NUL_BYTE; k++) begin
          cmd[len] = id_mem[k];
          len++;
        end
        for (int k = 0; k < TAIL_LEN; k++) begin
          cmd[len] = TAIL_TXT[8*(TAIL_LEN-1-k) +: 8];
          len++;
        end
        for (int k = 0; k < VALUE_CMD_LEN; k++)
          push_beat(KIND_TX, ST_IDLE, cmd[k], 4'h0, 1'b0);
      end
      push_beat(KIND_STATUS, ST_IDLE, 8'h00, 4'h0, 1'b1);
    end
  endtask

  // Compare an accepted output beat with the oldest expectation
  task automatic compare_beat();
    beat_t want;
    beat_no++;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("beat %0d arrived with nothing expected (kind %b tx %h)",
                                beat_no, kind, tx_byte));
    end else begin
      want = expected_beats.pop_front();
      check_field("kind", 8'(kind), 8'(want.kind));
      check_field("status", 8'(status), 8'(want.status));
      check_field("tx_byte", tx_byte, want.tx_byte);
      check_field("sensor_value", 8'(sensor_value), 8'(want.value));
      check_field("last", 8'(last), 8'(want.last));
    end
  endtask

  // Track register writes, check output beats, predict from input beats
  always @(posedge clk) begin
    if (rst) begin
      expected_beats.delete();
      pkt_count = 0;
      id_len    = 0;
      retries   = 0;
      phase     = PH_IDENT;
      retry_lim = RETRY_LIMIT_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
        retry_lim = pwdata[3:0];
      if (out_valid && !out_stall) compare_beat();
      if (in_valid && !in_stall) begin
        if (mode == POLL_MODE) begin
          predict_poll();
        end else if (pkt_count < PACKET_DEPTH) begin
          pkt_mem[pkt_count] = rx_byte;
          pkt_count++;
        end
      end
    end
    errors      <= err_cnt;
    outstanding <= expected_beats.size();
  end

endmodule

[tb/sensor_query_retry_parser_top_tb.sv]
// ----------------------------------------------------------------------------
// sensor_query_retry_parser_top_tb: testbench of the presence sensor poller
// Drives sensor replies (well-formed identity and value packets, truncated
// and corrupted ones, floods past the buffer) and polls through the input
// channel with random gaps, stalls the output channel at random, and steps
// the retry limit through several settings. The checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module sensor_query_retry_parser_top_tb;
  import sqrp_pkg::*;

  localparam int         PACKET_DEPTH     = 64;
  localparam int         ID_DEPTH         = 23;
  localparam logic [2:0] ADDR_RETRY_LIMIT = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;
  localparam logic       MODE_BYTE        = 1'b0;
  localparam logic       MODE_POLL        = 1'b1;
  localparam int         CYCLE_LIMIT      = 1_000_000;
  localparam int         SETTLE_CYCLES    = 120;

  typedef enum {
    SH_IDENT, SH_VALUE, SH_TRUNC_ID, SH_TRUNC_VAL, SH_NOISE, SH_EMPTY, SH_FLOOD
  } shape_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [1:0]  status;
  logic [7:0]  tx_byte;
  logic [3:0]  sensor_value;
  logic        last;
  int          errors;
  int          outstanding;

  logic [7:0]  reply[$];
  int          items_sent = 0;
  bit          calm = 0;
  int          cycles = 0;
  int          stall_left = 0;
  int          window_left = 0;
  bit          quiet = 0;
  int          stall_roll;

  sensor_query_retry_parser_top #(
    .PACKET_MAX (PACKET_DEPTH),
    .ID_MAX     (ID_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .status       (status),
    .tx_byte      (tx_byte),
    .sensor_value (sensor_value),
    .last         (last)
  );

  sensor_query_retry_parser_checker #(
    .PACKET_DEPTH (PACKET_DEPTH),
    .ID_DEPTH     (ID_DEPTH),
    .LIMIT_ADDR   (ADDR_RETRY_LIMIT),
    .POLL_MODE    (MODE_POLL)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .status       (status),
    .tx_byte      (tx_byte),
    .sensor_value (sensor_value),
    .last         (last),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stall the output side: mostly short holds, a few long, quiet windows between
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (window_left == 0) begin
        quiet       = ($urandom_range(0, 2) == 0);
        window_left = $urandom_range(50, 300);
      end else begin
        window_left--;
      end
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_roll = $urandom_range(0, 99);
        if (stall_roll < 55) begin
          out_stall <= 1'b0;
        end else begin
          stall_left = (stall_roll < 92) ? $urandom_range(0, 2) : $urandom_range(7, 19);
          out_stall <= 1'b1;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // Present one input beat, hold it until taken, then maybe idle
  task automatic send_item(input logic m, input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    mode     <= m;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Feed the buffered reply bytes, then poll
  task automatic send_reply();
    foreach (reply[i]) send_item(MODE_BYTE, reply[i]);
    send_item(MODE_POLL, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_text(input logic [23:0] txt);
    reply.push_back(txt[23:16]);
    reply.push_back(txt[15:8]);
    reply.push_back(txt[7:0]);
  endtask

  // Identity bytes: never a carriage return, now and then a zero byte
  task automatic add_id_bytes(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        b = NUL_BYTE;
      end else begin
        b = 8'($urandom_range(0, 255));
        while (b == CR_BYTE) b = 8'($urandom_range(0, 255));
      end
      reply.push_back(b);
    end
  endtask

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++) reply.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic int pick_id_len();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(0, 6) : $urandom_range(18, 30);
  endfunction

  // Build one sensor reply of a random shape
  task automatic build_reply();
    int     r;
    shape_t shape;
    r = $urandom_range(0, 99);
    if (r < 28)      shape = SH_IDENT;
    else if (r < 58) shape = SH_VALUE;
    else if (r < 66) shape = SH_TRUNC_ID;
    else if (r < 74) shape = SH_TRUNC_VAL;
    else if (r < 84) shape = SH_NOISE;
    else if (r < 96) shape = SH_EMPTY;
    else             shape = SH_FLOOD;
    reply.delete();
    calm = ($urandom_range(0, 3) == 0);
    case (shape)
      SH_IDENT: begin
        push_text("ID=");
        add_id_bytes(pick_id_len());
        reply.push_back(CR_BYTE);
        add_noise($urandom_range(0, 2));
      end
      SH_VALUE: begin
        push_text("ID=");
        add_noise($urandom_range(0, 4));
        push_text("BT=");
        add_noise($urandom_range(1, 3));
      end
      SH_TRUNC_ID: begin
        push_text("ID=");
        add_id_bytes(pick_id_len());
      end
      SH_TRUNC_VAL: begin
        push_text("ID=");
        add_noise($urandom_range(0, 3));
        push_text("BT=");
      end
      SH_NOISE: begin
        add_noise($urandom_range(1, 8));
      end
      SH_EMPTY: begin
      end
      SH_FLOOD: begin
        // run past the buffer so the tail is dropped or only just kept
        push_text("ID=");
        add_id_bytes($urandom_range(52, 72));
        if ($urandom_range(0, 1) == 0) begin
          reply.push_back(CR_BYTE);
        end else begin
          push_text("BT=");
          add_noise(1);
        end
      end
      default: begin
      end
    endcase
    // break the prefix now and then
    if (reply.size() > 0 && $urandom_range(0, 9) == 0) reply[0] = 8'($urandom_range(0, 255));
  endtask

  task automatic run_random(input int quota);
    int start;
    start = items_sent;
    while (items_sent - start < quota) begin
      build_reply();
      send_reply();
    end
  endtask

  // Drop valid, wait for every expected beat, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Set the retry limit, with junk in the unused upper bits
  task automatic program_limit(input logic [3:0] lim);
    logic [27:0] junk;
    junk = 28'($urandom);
    reg_write(ADDR_RETRY_LIMIT, {junk, lim});
  endtask

  initial begin
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    mode     = MODE_BYTE;
    rx_byte  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset limit, identity query, zero byte in identity,
    // value query, value with all-ones byte, no prefix, retries to failure
    reply.delete();
    send_reply();
    push_text("ID=");
    reply.push_back("A");
    reply.push_back(NUL_BYTE);
    reply.push_back("B");
    reply.push_back(CR_BYTE);
    send_reply();
    reply.delete();
    send_reply();
    push_text("ID=");
    push_text("BT=");
    reply.push_back(8'hff);
    send_reply();
    reply.delete();
    reply.push_back(8'h00);
    send_reply();
    reply.delete();
    send_reply();
    send_reply();
    settle();

    // Random phases across retry limit settings
    program_limit(4'd0);
    run_random(45);
    settle();
    program_limit(4'd15);
    run_random(40);
    settle();
    reg_write(ADDR_UNMAPPED, $urandom);
    program_limit(4'($urandom_range(1, 14)));
    run_random(45);
    settle();
    program_limit(4'($urandom_range(0, 15)));
    run_random(40);
    settle();

    if (errors == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sensor_query_retry_parser_top.f]
design/sqrp_pkg.sv
design/sensor_query_retry_parser_top.sv
tb/sensor_query_retry_parser_checker.sv
tb/sensor_query_retry_parser_top_tb.sv
